// ===== hdl/lesf_pkg.sv =====
// ----------------------------------------------------------------------------
// lesf_pkg: shared types and constants of the largest empty square finder
// Field widths, register map, reset values and the per-cell flag group.
// ----------------------------------------------------------------------------
`default_nettype none

package lesf_pkg;

  // fixed field widths
  localparam int CHAR_W    = 8;
  localparam int SIZE_W    = 11;
  localparam int POS_W     = 10;
  localparam int DIM_W     = 11;

  // configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  // default geometry limits
  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;

  // register reset values
  localparam int NUM_COLS_RST   = 1024;
  localparam int NUM_ROWS_RST   = 1024;
  localparam int EMPTY_CHAR_RST = 46;

  // register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_NUM_COLS   = 2'd0,
    REG_NUM_ROWS   = 2'd1,
    REG_EMPTY_CHAR = 2'd2
  } reg_idx_t;

  // per-cell position and free flags from the scan counters
  typedef struct packed {
    logic bottom;
    logic rightmost;
    logic done;
    logic is_free;
  } cell_flags_t;

endpackage

`default_nettype wire

// ===== hdl/lesf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lesf_cfg_regs: configuration registers
// APB-style register file for grid geometry and the empty character, with
// the clamped last column/row indexes used by the scan counters.
// ----------------------------------------------------------------------------
`default_nettype none

module lesf_cfg_regs #(
  parameter int MAX_COLS = lesf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lesf_pkg::MAX_ROWS_DEF,
  parameter int CW       = 10,
  parameter int RW       = 10
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lesf_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lesf_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [lesf_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  output logic      [lesf_pkg::CHAR_W-1:0]     empty_char,
  output logic      [CW-1:0]                   last_col,
  output logic      [RW-1:0]                   last_row,
  output logic      [CW-1:0]                   last_col_next,
  output logic      [RW-1:0]                   last_row_next,
  output logic                                 restart
);

  logic [lesf_pkg::DIM_W-1:0] num_cols, num_cols_next;
  logic [lesf_pkg::DIM_W-1:0] num_rows, num_rows_next;
  logic [1:0]                 idx;
  logic                       wr;
  logic                       wr_cols, wr_rows, wr_char;

  // clamp to 1..MAX and return the last index
  function automatic logic [CW-1:0] col_last(input logic [lesf_pkg::DIM_W-1:0] v);
    if (v == '0) return '0;
    else if (32'(v) > 32'(MAX_COLS)) return CW'(MAX_COLS - 1);
    else return CW'(v - lesf_pkg::DIM_W'(1));
  endfunction

  function automatic logic [RW-1:0] row_last(input logic [lesf_pkg::DIM_W-1:0] v);
    if (v == '0) return '0;
    else if (32'(v) > 32'(MAX_ROWS)) return RW'(MAX_ROWS - 1);
    else return RW'(v - lesf_pkg::DIM_W'(1));
  endfunction

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite && pready;

  // write decode
  always_comb begin
    wr_cols = 1'b0;
    wr_rows = 1'b0;
    wr_char = 1'b0;
    case (idx)
      lesf_pkg::REG_NUM_COLS:   wr_cols = wr;
      lesf_pkg::REG_NUM_ROWS:   wr_rows = wr;
      lesf_pkg::REG_EMPTY_CHAR: wr_char = wr;
      default: ;
    endcase
  end

  assign num_cols_next = wr_cols ? pwdata[lesf_pkg::DIM_W-1:0] : num_cols;
  assign num_rows_next = wr_rows ? pwdata[lesf_pkg::DIM_W-1:0] : num_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols   <= lesf_pkg::DIM_W'(lesf_pkg::NUM_COLS_RST);
      num_rows   <= lesf_pkg::DIM_W'(lesf_pkg::NUM_ROWS_RST);
      empty_char <= lesf_pkg::CHAR_W'(lesf_pkg::EMPTY_CHAR_RST);
    end else begin
      num_cols <= num_cols_next;
      num_rows <= num_rows_next;
      if (wr_char) empty_char <= pwdata[lesf_pkg::CHAR_W-1:0];
    end
  end

  // geometry writes restart the scan
  assign restart       = wr_cols || wr_rows;
  assign last_col      = col_last(num_cols);
  assign last_row      = row_last(num_rows);
  assign last_col_next = col_last(num_cols_next);
  assign last_row_next = row_last(num_rows_next);

  // read mux
  always_comb begin
    prdata = '0;
    case (idx)
      lesf_pkg::REG_NUM_COLS:   prdata = lesf_pkg::APB_DATA_W'(num_cols);
      lesf_pkg::REG_NUM_ROWS:   prdata = lesf_pkg::APB_DATA_W'(num_rows);
      lesf_pkg::REG_EMPTY_CHAR: prdata = lesf_pkg::APB_DATA_W'(empty_char);
      default:                  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/lesf_scan.sv =====
// ----------------------------------------------------------------------------
// lesf_scan: reverse raster scan counters
// Tracks the column and row of the next cell and derives its edge and free flags.
// ----------------------------------------------------------------------------
`default_nettype none

module lesf_scan #(
  parameter int MAX_COLS = lesf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lesf_pkg::MAX_ROWS_DEF,
  parameter int CW       = 10,
  parameter int RW       = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic                        restart,
  input  wire logic [CW-1:0]               last_col,
  input  wire logic [RW-1:0]               last_row,
  input  wire logic [CW-1:0]               last_col_next,
  input  wire logic [RW-1:0]               last_row_next,
  input  wire logic [lesf_pkg::CHAR_W-1:0] empty_char,
  input  wire logic [lesf_pkg::CHAR_W-1:0] cell_char,
  output logic      [CW-1:0]               col,
  output logic      [RW-1:0]               row,
  output lesf_pkg::cell_flags_t            flags
);

  localparam int RST_LAST_COL =
    (lesf_pkg::NUM_COLS_RST > MAX_COLS ? MAX_COLS : lesf_pkg::NUM_COLS_RST) - 1;
  localparam int RST_LAST_ROW =
    (lesf_pkg::NUM_ROWS_RST > MAX_ROWS ? MAX_ROWS : lesf_pkg::NUM_ROWS_RST) - 1;

  // flags of the cell under the counters
  always_comb begin
    flags.bottom    = (row == last_row);
    flags.rightmost = (col == last_col);
    flags.done      = (col == '0) && (row == '0);
    flags.is_free   = (cell_char == empty_char);
  end

  // step right to left, then up one row; wrap after the top-left cell
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= CW'(RST_LAST_COL);
      row <= RW'(RST_LAST_ROW);
    end else if (restart) begin
      col <= last_col_next;
      row <= last_row_next;
    end else if (accept) begin
      if (flags.done) begin
        col <= last_col;
        row <= last_row;
      end else if (col == '0) begin
        col <= last_col;
        row <= row - RW'(1);
      end else begin
        col <= col - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lesf_row_buf.sv =====
// ----------------------------------------------------------------------------
// lesf_row_buf: row buffer of square sizes
// One write and one registered read per cycle; a read of the address being
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module lesf_row_buf #(
  parameter int DEPTH = lesf_pkg::MAX_COLS_DEF,
  parameter int AW    = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [lesf_pkg::SIZE_W-1:0] wr_data,
  output logic      [lesf_pkg::SIZE_W-1:0] rd_data
);

  logic [lesf_pkg::SIZE_W-1:0] mem [DEPTH];
  logic [lesf_pkg::SIZE_W-1:0] mem_q;
  logic [lesf_pkg::SIZE_W-1:0] byp_data;
  logic                        byp;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) mem_q <= mem[rd_addr];
  end

  // same-address forwarding
  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp      <= wr_en && (wr_addr == rd_addr);
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp ? byp_data : mem_q;

endmodule

`default_nettype wire

// ===== hdl/lesf_cell_stage.sv =====
// ----------------------------------------------------------------------------
// lesf_cell_stage: cell register, size update and result register
// Computes 1 + min(below, right, diagonal) for a free cell, tracks the best
// square and holds the result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lesf_cell_stage #(
  parameter int CW = 10,
  parameter int RW = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic                        restart,
  input  wire logic [CW-1:0]               col_in,
  input  wire logic [RW-1:0]               row_in,
  input  wire lesf_pkg::cell_flags_t       flags_in,
  input  wire logic [lesf_pkg::SIZE_W-1:0] below_mem,
  input  wire logic                        out_stall,
  output logic                             in_stall,
  output logic                             wr_en,
  output logic      [CW-1:0]               wr_addr,
  output logic      [lesf_pkg::SIZE_W-1:0] wr_data,
  output logic                             out_valid,
  output logic      [lesf_pkg::SIZE_W-1:0] cell_size,
  output logic      [lesf_pkg::POS_W-1:0]  best_col,
  output logic      [lesf_pkg::POS_W-1:0]  best_row,
  output logic      [lesf_pkg::SIZE_W-1:0] best_size,
  output logic                             grid_done
);

  localparam int SW = lesf_pkg::SIZE_W;

  // cell register
  logic                  s1_valid;
  logic [CW-1:0]         s1_col;
  logic [RW-1:0]         s1_row;
  lesf_pkg::cell_flags_t s1_flags;

  // running state
  logic [SW-1:0] right_size, diag_size, best_sz;
  logic [CW-1:0] best_c;
  logic [RW-1:0] best_r;

  logic [SW-1:0] below, right, diag, m_br, m_all, size;
  logic          best_upd, fire;
  logic [SW-1:0] best_sz_new;
  logic [CW-1:0] best_c_new;
  logic [RW-1:0] best_r_new;

  // neighbours outside the grid count as zero
  always_comb begin
    below = s1_flags.bottom ? '0 : below_mem;
    right = s1_flags.rightmost ? '0 : right_size;
    diag  = (s1_flags.bottom || s1_flags.rightmost) ? '0 : diag_size;
    m_br  = (below < right) ? below : right;
    m_all = (m_br < diag) ? m_br : diag;
    size  = s1_flags.is_free ? m_all + SW'(1) : '0;
  end

  // best square; ties go to the later scanned cell
  always_comb begin
    best_upd    = (size != '0) && (size >= best_sz);
    best_sz_new = best_upd ? size : best_sz;
    best_c_new  = best_upd ? s1_col : best_c;
    best_r_new  = best_upd ? s1_row : best_r;
  end

  assign fire     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign wr_en    = fire;
  assign wr_addr  = s1_col;
  assign wr_data  = size;

  // cell register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= col_in;
      s1_row   <= row_in;
      s1_flags <= flags_in;
    end
  end

  // running state update
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      right_size <= '0;
      diag_size  <= '0;
      best_sz    <= '0;
      best_c     <= '0;
      best_r     <= '0;
    end else if (fire) begin
      if (s1_flags.done) begin
        right_size <= '0;
        diag_size  <= '0;
        best_sz    <= '0;
        best_c     <= '0;
        best_r     <= '0;
      end else begin
        if (s1_col == '0) begin
          right_size <= '0;
          diag_size  <= '0;
        end else begin
          right_size <= size;
          diag_size  <= below;
        end
        best_sz <= best_sz_new;
        best_c  <= best_c_new;
        best_r  <= best_r_new;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cell_size <= size;
      best_col  <= lesf_pkg::POS_W'(best_c_new);
      best_row  <= lesf_pkg::POS_W'(best_r_new);
      best_size <= best_sz_new;
      grid_done <= s1_flags.done;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/largest_empty_square_finder_unit.sv =====
// ----------------------------------------------------------------------------
// largest_empty_square_finder_unit: maximal free square over a byte grid
// Scans cells in reverse raster order and reports the largest free square.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / cell_char): one beat per grid cell,
//   bottom row first, right to left within a row.
//   Output channel (out_valid / out_stall / cell_size, best_*, grid_done):
//   one beat per cell; grid_done marks the top-left cell, whose best fields
//   hold the final answer. The scan then starts over on a new grid.
//   Path: an accepted cell is held in the cell register, and its result is
//   registered in the result register. Throughput: one cell per cycle while
//   no result is stalled, set by the combinational size update and the row
//   buffer's one read and one write port per cycle.
//   Stall: while out_stall holds a result, one more cell may enter the cell
//   register; after that in_stall rises until the result is taken.
//   Reset: counters point at the bottom-right cell, best square is cleared,
//   both channels are empty. The row buffer is not cleared: the bottom row
//   discards its reads; each later row reads only what the row below wrote.
//   Configuration: num_cols, num_rows, empty_char at byte addresses 0, 4, 8;
//   a geometry write restarts the scan. Write only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module largest_empty_square_finder_unit #(
  parameter int MAX_COLS = lesf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lesf_pkg::MAX_ROWS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lesf_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lesf_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [lesf_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [lesf_pkg::CHAR_W-1:0]     cell_char,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [lesf_pkg::SIZE_W-1:0]     cell_size,
  output logic      [lesf_pkg::POS_W-1:0]      best_col,
  output logic      [lesf_pkg::POS_W-1:0]      best_row,
  output logic      [lesf_pkg::SIZE_W-1:0]     best_size,
  output logic                                 grid_done
);

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [lesf_pkg::CHAR_W-1:0] empty_char;
  logic [CW-1:0]               last_col, last_col_next, col;
  logic [RW-1:0]               last_row, last_row_next, row;
  logic                        restart, accept;
  lesf_pkg::cell_flags_t       flags;
  logic                        wr_en;
  logic [CW-1:0]               wr_addr;
  logic [lesf_pkg::SIZE_W-1:0] wr_data, below_mem;

  assign accept = in_valid && !in_stall;

  lesf_cfg_regs #(
    .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .CW(CW), .RW(RW)
  ) u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .empty_char, .last_col, .last_row, .last_col_next, .last_row_next, .restart
  );

  lesf_scan #(
    .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .CW(CW), .RW(RW)
  ) u_scan (
    .clk, .rst, .accept, .restart, .last_col, .last_row, .last_col_next,
    .last_row_next, .empty_char, .cell_char, .col, .row, .flags
  );

  // row buffer read is issued as the cell is accepted
  lesf_row_buf #(
    .DEPTH(MAX_COLS), .AW(CW)
  ) u_row_buf (
    .clk, .rd_en(accept), .rd_addr(col), .wr_en, .wr_addr, .wr_data,
    .rd_data(below_mem)
  );

  lesf_cell_stage #(
    .CW(CW), .RW(RW)
  ) u_cell (
    .clk, .rst, .accept, .restart, .col_in(col), .row_in(row),
    .flags_in(flags), .below_mem, .out_stall, .in_stall, .wr_en, .wr_addr,
    .wr_data, .out_valid, .cell_size, .best_col, .best_row, .best_size,
    .grid_done
  );

endmodule

`default_nettype wire

// ===== hdl/lesf_checker.sv =====
// ----------------------------------------------------------------------------
// lesf_checker: port-level checks of the square finder
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module lesf_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [lesf_pkg::SIZE_W-1:0] cell_size,
  input wire logic [lesf_pkg::POS_W-1:0]  best_col,
  input wire logic [lesf_pkg::POS_W-1:0]  best_row,
  input wire logic [lesf_pkg::SIZE_W-1:0] best_size,
  input wire logic                        grid_done
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cell_size) &&
      $stable(best_size) && $stable(best_col) && $stable(best_row) &&
      $stable(grid_done))
    else $error("result beat changed while stalled");

  // input backs up only behind a stalled result
  a_in_stall: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // best square covers the current cell's square
  a_best_ge: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cell_size <= best_size)
    else $error("cell square larger than best square");

  // no square means a zero corner
  a_best_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && best_size == '0 |-> best_col == '0 && best_row == '0)
    else $error("nonzero corner with no square");

  // reset empties the output
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat after reset");

endmodule

bind largest_empty_square_finder_unit lesf_checker u_lesf_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .cell_size, .best_col,
  .best_row, .best_size, .grid_done
);

`default_nettype wire
